// File: hdl/disc_pair_elastic_collision_core_defines.svh
// ----------------------------------------------------------------------------
// disc_pair_elastic_collision_core_defines
// Assertion macros for the disc pair collision block.
// ----------------------------------------------------------------------------
`ifndef DISC_PAIR_ELASTIC_COLLISION_CORE_DEFINES_SVH
`define DISC_PAIR_ELASTIC_COLLISION_CORE_DEFINES_SVH

// property must hold at every clock outside reset
`define DPEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define DPEC_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hdl/dpec_pkg.sv
// ----------------------------------------------------------------------------
// dpec_pkg
// Types, step counts and fixed-point helpers for the disc collision block.
// ----------------------------------------------------------------------------
package dpec_pkg;

	localparam logic [31:0] RADIUS_RESET = 32'd1638400;
	localparam int unsigned SQRT_STEPS = 33;
	localparam int unsigned NDIV_STEPS = 17;
	localparam int unsigned WDIV_STEPS = 25;
	localparam int unsigned QDEPTH = 2;

	// item as formed by the front end
	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [32:0] vrx;
		logic signed [32:0] vry;
		logic signed [31:0] va_x;
		logic signed [31:0] va_y;
		logic signed [31:0] vb_x;
		logic signed [31:0] vb_y;
		logic [31:0] ma;
		logic [31:0] mb;
		logic [32:0] twor;
	} fitem_t;

	// fields carried alongside the iterative units
	typedef struct packed {
		logic [32:0] adx;
		logic [32:0] ady;
		logic sdx;
		logic sdy;
		logic signed [32:0] vrx;
		logic signed [32:0] vry;
		logic signed [31:0] va_x;
		logic signed [31:0] va_y;
		logic signed [31:0] vb_x;
		logic signed [31:0] vb_y;
		logic [32:0] twor;
		logic mzero;
	} carry_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) r = 32'sh7fffffff;
		else if (v < -64'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// arithmetic shift right rounding toward zero
	function automatic logic signed [63:0] sra_tz(input logic signed [63:0] v,
		input logic [5:0] k);
		logic signed [63:0] bias;
		bias = (64'sd1 <<< k) - 64'sd1;
		return v[63] ? ((v + bias) >>> k) : (v >>> k);
	endfunction

endpackage

// File: hdl/dpec_front.sv
// ----------------------------------------------------------------------------
// dpec_front
// Accepts a disc pair, forms differences and holds it until the queue takes it.
// ----------------------------------------------------------------------------
module dpec_front (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] a_pos_x,
	input  logic signed [31:0] a_pos_y,
	input  logic signed [31:0] b_pos_x,
	input  logic signed [31:0] b_pos_y,
	input  logic signed [31:0] a_vel_x,
	input  logic signed [31:0] a_vel_y,
	input  logic signed [31:0] b_vel_x,
	input  logic signed [31:0] b_vel_y,
	input  logic [31:0] a_mass,
	input  logic [31:0] b_mass,
	input  logic [31:0] radius,
	input  logic q_full,
	output logic push,
	output dpec_pkg::fitem_t item
);

	logic valid_q;
	dpec_pkg::fitem_t item_q;
	logic accept;

	assign busy   = valid_q & q_full;
	assign accept = start & ~busy;
	assign push   = valid_q & ~q_full;
	assign item   = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (accept) valid_q <= 1'b1;
		else if (push) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.dx   <= 33'(a_pos_x) - 33'(b_pos_x);
			item_q.dy   <= 33'(a_pos_y) - 33'(b_pos_y);
			item_q.vrx  <= 33'(a_vel_x) - 33'(b_vel_x);
			item_q.vry  <= 33'(a_vel_y) - 33'(b_vel_y);
			item_q.va_x <= a_vel_x;
			item_q.va_y <= a_vel_y;
			item_q.vb_x <= b_vel_x;
			item_q.vb_y <= b_vel_y;
			item_q.ma   <= a_mass;
			item_q.mb   <= b_mass;
			item_q.twor <= {radius, 1'b0};
		end
	end

endmodule

// File: hdl/dpec_queue.sv
// ----------------------------------------------------------------------------
// dpec_queue
// Short queue between front and back end.
// ----------------------------------------------------------------------------
module dpec_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dpec_pkg::fitem_t wr_item,
	output logic full,
	output logic pop,
	output dpec_pkg::fitem_t rd_item
);

	localparam int unsigned PW = $clog2(dpec_pkg::QDEPTH);

	dpec_pkg::fitem_t mem_q [dpec_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;

	assign full    = (count_q == (PW+1)'(dpec_pkg::QDEPTH));
	assign pop     = (count_q != '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// File: hdl/dpec_back.sv
// ----------------------------------------------------------------------------
// dpec_back
// Pipelined response: distance root, normal and mass-share dividers, impulse.
// ----------------------------------------------------------------------------
module dpec_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  dpec_pkg::fitem_t in_item,
	output logic done,
	output logic collided,
	output logic signed [31:0] new_a_vel_x,
	output logic signed [31:0] new_a_vel_y,
	output logic signed [31:0] new_b_vel_x,
	output logic signed [31:0] new_b_vel_y,
	output logic signed [31:0] shift_x,
	output logic signed [31:0] shift_y
);

	localparam int unsigned NS = dpec_pkg::SQRT_STEPS;
	localparam int unsigned ND = dpec_pkg::NDIV_STEPS;
	localparam int unsigned NW = dpec_pkg::WDIV_STEPS;

	// ---- squares
	logic v_s1, v_s2;
	logic [65:0] sq1_s1, sq2_s1, sum_s2;
	dpec_pkg::carry_t car_s1, car_s2;
	logic [32:0] msum_s1, msum_s2;
	logic [31:0] ma_s1, mb_s1, ma_s2, mb_s2;
	logic [32:0] adx_c, ady_c;
	dpec_pkg::carry_t car_c;

	assign adx_c = in_item.dx[32] ? 33'(-in_item.dx) : 33'(in_item.dx);
	assign ady_c = in_item.dy[32] ? 33'(-in_item.dy) : 33'(in_item.dy);

	always_comb begin
		car_c.adx   = adx_c;
		car_c.ady   = ady_c;
		car_c.sdx   = in_item.dx[32];
		car_c.sdy   = in_item.dy[32];
		car_c.vrx   = in_item.vrx;
		car_c.vry   = in_item.vry;
		car_c.va_x  = in_item.va_x;
		car_c.va_y  = in_item.va_y;
		car_c.vb_x  = in_item.vb_x;
		car_c.vb_y  = in_item.vb_y;
		car_c.twor  = in_item.twor;
		car_c.mzero = (in_item.ma == '0) && (in_item.mb == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sq1_s1  <= adx_c * adx_c;
		sq2_s1  <= ady_c * ady_c;
		car_s1  <= car_c;
		msum_s1 <= 33'(in_item.ma) + 33'(in_item.mb);
		ma_s1   <= in_item.ma;
		mb_s1   <= in_item.mb;
		sum_s2  <= sq1_s1 + sq2_s1;
		car_s2  <= car_s1;
		msum_s2 <= msum_s1;
		ma_s2   <= ma_s1;
		mb_s2   <= mb_s1;
	end

	// ---- square root, two radicand bits a step; mass shares ride along
	logic sv [NS+1];
	logic [33:0] srem [NS+1];
	logic [32:0] sroot [NS+1];
	logic [65:0] sval [NS+1];
	dpec_pkg::carry_t scar [NS+1];
	logic [32:0] msum_k [NS+1];
	logic [32:0] wra [NS+1], wrb [NS+1];
	logic [24:0] wqa [NS+1], wqb [NS+1];
	logic ma0 [NS+1], mb0 [NS+1];

	assign sv[0]     = v_s2;
	assign srem[0]   = '0;
	assign sroot[0]  = '0;
	assign sval[0]   = sum_s2;
	assign scar[0]   = car_s2;
	assign msum_k[0] = msum_s2;
	assign wra[0]    = {2'b00, ma_s2[31:1]};
	assign wrb[0]    = {2'b00, mb_s2[31:1]};
	assign wqa[0]    = '0;
	assign wqb[0]    = '0;
	assign ma0[0]    = ma_s2[0];
	assign mb0[0]    = mb_s2[0];

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		logic [35:0] rem_n, trial;
		logic ge;
		assign rem_n = {srem[k], sval[k][65:64]};
		assign trial = {1'b0, sroot[k], 2'b01};
		assign ge    = (rem_n >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else sv[k+1] <= sv[k];
		end

		always_ff @(posedge clk) begin
			srem[k+1]   <= ge ? 34'(rem_n - trial) : 34'(rem_n);
			sroot[k+1]  <= {sroot[k][31:0], ge};
			sval[k+1]   <= sval[k] << 2;
			scar[k+1]   <= scar[k];
			msum_k[k+1] <= msum_k[k];
			ma0[k+1]    <= ma0[k];
			mb0[k+1]    <= mb0[k];
		end

		if (k < NW) begin : g_wdiv
			logic [33:0] ra_n, rb_n;
			logic ga, gb;
			assign ra_n = {wra[k], (k == 0) ? ma0[k] : 1'b0};
			assign rb_n = {wrb[k], (k == 0) ? mb0[k] : 1'b0};
			assign ga   = (ra_n >= {1'b0, msum_k[k]});
			assign gb   = (rb_n >= {1'b0, msum_k[k]});
			always_ff @(posedge clk) begin
				wra[k+1] <= ga ? 33'(ra_n - {1'b0, msum_k[k]}) : 33'(ra_n);
				wrb[k+1] <= gb ? 33'(rb_n - {1'b0, msum_k[k]}) : 33'(rb_n);
				wqa[k+1] <= {wqa[k][23:0], ga};
				wqb[k+1] <= {wqb[k][23:0], gb};
			end
		end else begin : g_whold
			always_ff @(posedge clk) begin
				wra[k+1] <= wra[k];
				wrb[k+1] <= wrb[k];
				wqa[k+1] <= wqa[k];
				wqb[k+1] <= wqb[k];
			end
		end
	end

	// ---- unit normal: |d| * 2^16 / dist, quotient fits 17 bits
	logic dv [ND+1];
	logic [32:0] drx [ND+1], dry [ND+1], dist_k [ND+1];
	logic [16:0] dqx [ND+1], dqy [ND+1];
	logic [24:0] dwa [ND+1], dwb [ND+1];
	dpec_pkg::carry_t dcar [ND+1];

	assign dv[0]     = sv[NS];
	assign drx[0]    = {1'b0, scar[NS].adx[32:1]};
	assign dry[0]    = {1'b0, scar[NS].ady[32:1]};
	assign dist_k[0] = sroot[NS];
	assign dqx[0]    = '0;
	assign dqy[0]    = '0;
	assign dwa[0]    = wqa[NS];
	assign dwb[0]    = wqb[NS];
	assign dcar[0]   = scar[NS];

	for (genvar j = 0; j < ND; j++) begin : g_ndiv
		logic [33:0] rx_n, ry_n;
		logic gx, gy;
		assign rx_n = {drx[j], (j == 0) ? dcar[j].adx[0] : 1'b0};
		assign ry_n = {dry[j], (j == 0) ? dcar[j].ady[0] : 1'b0};
		assign gx   = (rx_n >= {1'b0, dist_k[j]});
		assign gy   = (ry_n >= {1'b0, dist_k[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[j+1] <= 1'b0;
			else dv[j+1] <= dv[j];
		end

		always_ff @(posedge clk) begin
			drx[j+1]    <= gx ? 33'(rx_n - {1'b0, dist_k[j]}) : 33'(rx_n);
			dry[j+1]    <= gy ? 33'(ry_n - {1'b0, dist_k[j]}) : 33'(ry_n);
			dqx[j+1]    <= {dqx[j][15:0], gx};
			dqy[j+1]    <= {dqy[j][15:0], gy};
			dist_k[j+1] <= dist_k[j];
			dwa[j+1]    <= dwa[j];
			dwb[j+1]    <= dwb[j];
			dcar[j+1]   <= dcar[j];
		end
	end

	// ---- response
	logic v_p1, v_p2, v_p3, v_p4, v_p5, v_p6;
	logic signed [17:0] nx_c, ny_c;
	logic signed [17:0] nx_p1, ny_p1, nx_p2, ny_p2, nx_p3, ny_p3;
	logic signed [17:0] nx_p4, ny_p4, nx_p5, ny_p5;
	logic signed [50:0] px_p1, py_p1;
	logic [32:0] ovl_p1;
	logic hitd_p1, hitd_p2;
	logic [24:0] wa_p1, wb_p1, wa_p2, wb_p2, wa_p3, wb_p3;
	dpec_pkg::carry_t c_p1, c_p2, c_p3, c_p4, c_p5, c_p6;
	logic signed [51:0] s_p2, ox_p2, oy_p2;
	logic signed [35:0] vdn_p3;
	logic hit_p3, hit_p4, hit_p5, hit_p6;
	logic signed [31:0] shx_p3, shy_p3, shx_p4, shy_p4, shx_p5, shy_p5, shx_p6, shy_p6;
	logic signed [62:0] kap_p4, kbp_p4;
	logic signed [38:0] ka_p5, kb_p5;
	logic signed [56:0] pax_p6, pay_p6, pbx_p6, pby_p6;
	logic hit_c;

	assign nx_c = dcar[ND].sdx ? -$signed({1'b0, dqx[ND]}) : $signed({1'b0, dqx[ND]});
	assign ny_c = dcar[ND].sdy ? -$signed({1'b0, dqy[ND]}) : $signed({1'b0, dqy[ND]});
	assign hit_c = hitd_p2 && (s_p2 <= 52'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
			v_p4 <= 1'b0;
			v_p5 <= 1'b0;
			v_p6 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_p1 <= dv[ND];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
			v_p4 <= v_p3;
			v_p5 <= v_p4;
			v_p6 <= v_p5;
			done <= v_p6;
		end
	end

	always_ff @(posedge clk) begin
		// P1: normal and relative-velocity products
		nx_p1   <= nx_c;
		ny_p1   <= ny_c;
		px_p1   <= dcar[ND].vrx * nx_c;
		py_p1   <= dcar[ND].vry * ny_c;
		ovl_p1  <= dcar[ND].twor - dist_k[ND];
		hitd_p1 <= (dist_k[ND] != '0) && (dist_k[ND] < dcar[ND].twor);
		wa_p1   <= dwa[ND];
		wb_p1   <= dwb[ND];
		c_p1    <= dcar[ND];
		// P2: dot product, overlap products
		s_p2    <= 52'(px_p1) + 52'(py_p1);
		ox_p2   <= nx_p1 * $signed({1'b0, ovl_p1});
		oy_p2   <= ny_p1 * $signed({1'b0, ovl_p1});
		nx_p2   <= nx_p1;
		ny_p2   <= ny_p1;
		hitd_p2 <= hitd_p1;
		wa_p2   <= wa_p1;
		wb_p2   <= wb_p1;
		c_p2    <= c_p1;
		// P3: contact decision, shift
		vdn_p3  <= 36'(dpec_pkg::sra_tz(64'(s_p2), 6'd16));
		hit_p3  <= hit_c;
		shx_p3  <= hit_c ? dpec_pkg::sat32(dpec_pkg::sra_tz(64'(ox_p2), 6'd17)) : '0;
		shy_p3  <= hit_c ? dpec_pkg::sat32(dpec_pkg::sra_tz(64'(oy_p2), 6'd17)) : '0;
		nx_p3   <= nx_p2;
		ny_p3   <= ny_p2;
		wa_p3   <= wa_p2;
		wb_p3   <= wb_p2;
		c_p3    <= c_p2;
		// P4: impulse times the other disc's share
		kap_p4  <= 63'(vdn_p3 * $signed({1'b0, wb_p3})) <<< 1;
		kbp_p4  <= 63'(vdn_p3 * $signed({1'b0, wa_p3})) <<< 1;
		hit_p4  <= hit_p3;
		shx_p4  <= shx_p3;
		shy_p4  <= shy_p3;
		nx_p4   <= nx_p3;
		ny_p4   <= ny_p3;
		c_p4    <= c_p3;
		// P5
		ka_p5   <= 39'(dpec_pkg::sra_tz(64'(kap_p4), 6'd24));
		kb_p5   <= 39'(dpec_pkg::sra_tz(64'(kbp_p4), 6'd24));
		hit_p5  <= hit_p4;
		shx_p5  <= shx_p4;
		shy_p5  <= shy_p4;
		nx_p5   <= nx_p4;
		ny_p5   <= ny_p4;
		c_p5    <= c_p4;
		// P6: along the normal
		pax_p6  <= ka_p5 * nx_p5;
		pay_p6  <= ka_p5 * ny_p5;
		pbx_p6  <= kb_p5 * nx_p5;
		pby_p6  <= kb_p5 * ny_p5;
		hit_p6  <= hit_p5;
		shx_p6  <= shx_p5;
		shy_p6  <= shy_p5;
		c_p6    <= c_p5;
		// P7: result
		collided <= hit_p6;
		shift_x  <= shx_p6;
		shift_y  <= shy_p6;
		if (hit_p6 && !c_p6.mzero) begin
			new_a_vel_x <= dpec_pkg::sat32(64'(c_p6.va_x)
				- dpec_pkg::sra_tz(64'(pax_p6), 6'd16));
			new_a_vel_y <= dpec_pkg::sat32(64'(c_p6.va_y)
				- dpec_pkg::sra_tz(64'(pay_p6), 6'd16));
			new_b_vel_x <= dpec_pkg::sat32(64'(c_p6.vb_x)
				+ dpec_pkg::sra_tz(64'(pbx_p6), 6'd16));
			new_b_vel_y <= dpec_pkg::sat32(64'(c_p6.vb_y)
				+ dpec_pkg::sra_tz(64'(pby_p6), 6'd16));
		end else begin
			new_a_vel_x <= c_p6.va_x;
			new_a_vel_y <= c_p6.va_y;
			new_b_vel_x <= c_p6.vb_x;
			new_b_vel_y <= c_p6.vb_y;
		end
	end

endmodule

// File: hdl/disc_pair_elastic_collision_core.sv
// ----------------------------------------------------------------------------
// disc_pair_elastic_collision_core
// Elastic collision of two equal-radius discs, signed Q16.16.
//
//  channel   handshake          payload
//  config    cfg_we             cfg_wdata (disc radius)
//  input     start / busy       a_pos_*, b_pos_*, a_vel_*, b_vel_*, a_mass, b_mass
//  result    done (one cycle)   collided, new_a_vel_*, new_b_vel_*, shift_*
//
// One item per cycle; every result follows its item through the 33-step square
// root and the 17-step normal divider in the back end.
// Reset clears all valid state and sets the radius to 25.0.
// The back end never stalls, so busy only rises if the queue were to fill.
// ----------------------------------------------------------------------------
module disc_pair_elastic_collision_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic start,
	output logic busy,
	input  logic signed [31:0] a_pos_x,
	input  logic signed [31:0] a_pos_y,
	input  logic signed [31:0] b_pos_x,
	input  logic signed [31:0] b_pos_y,
	input  logic signed [31:0] a_vel_x,
	input  logic signed [31:0] a_vel_y,
	input  logic signed [31:0] b_vel_x,
	input  logic signed [31:0] b_vel_y,
	input  logic [31:0] a_mass,
	input  logic [31:0] b_mass,
	output logic done,
	output logic collided,
	output logic signed [31:0] new_a_vel_x,
	output logic signed [31:0] new_a_vel_y,
	output logic signed [31:0] new_b_vel_x,
	output logic signed [31:0] new_b_vel_y,
	output logic signed [31:0] shift_x,
	output logic signed [31:0] shift_y
);

	logic [31:0] radius_q;
	logic push, q_full, pop;
	dpec_pkg::fitem_t f_item, q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= dpec_pkg::RADIUS_RESET;
		else if (cfg_we) radius_q <= cfg_wdata;
	end

	dpec_front u_front (
		.clk, .arst_n, .start, .busy,
		.a_pos_x, .a_pos_y, .b_pos_x, .b_pos_y,
		.a_vel_x, .a_vel_y, .b_vel_x, .b_vel_y,
		.a_mass, .b_mass,
		.radius(radius_q), .q_full, .push, .item(f_item)
	);

	dpec_queue u_queue (
		.clk, .arst_n, .push, .wr_item(f_item), .full(q_full),
		.pop, .rd_item(q_item)
	);

	dpec_back u_back (
		.clk, .arst_n, .in_valid(pop), .in_item(q_item),
		.done, .collided,
		.new_a_vel_x, .new_a_vel_y, .new_b_vel_x, .new_b_vel_y,
		.shift_x, .shift_y
	);

endmodule

// File: hdl/dpec_checker.sv
// ----------------------------------------------------------------------------
// dpec_checker
// Port-level checks on the disc collision block.
// ----------------------------------------------------------------------------
`include "disc_pair_elastic_collision_core_defines.svh"

module dpec_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic collided,
	input logic signed [31:0] shift_x,
	input logic signed [31:0] shift_y
);

	// back end drains every cycle, so the queue can never fill
	`DPEC_NEVER(a_no_busy, busy, "busy raised although back end never stalls")
	`DPEC_ASSERT(a_no_shift, done && !collided |-> shift_x == 0 && shift_y == 0, "stray shift")
	`DPEC_ASSERT(a_start_taken, start |-> !busy, "item held off at start")
	`DPEC_ASSERT(a_idle_after_reset, $rose(arst_n) |-> !done, "result right after reset")

endmodule

bind disc_pair_elastic_collision_core dpec_checker u_dpec_checker (
	.clk, .arst_n, .start, .busy, .done, .collided, .shift_x, .shift_y
);

// File: test/tb_disc_pair_elastic_collision_core.sv
// ----------------------------------------------------------------------------
// tb_disc_pair_elastic_collision_core
// Drives disc pairs through the collision block under random start gaps and
// compares every result, field by field, with a built-in fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_disc_pair_elastic_collision_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 61;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct {
		logic signed [31:0] apx, apy, bpx, bpy, avx, avy, bvx, bvy;
		logic [31:0] ma, mb;
	} pair_t;

	typedef struct {
		logic hit;
		logic signed [31:0] navx, navy, nbvx, nbvy, shx, shy;
	} response_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	logic signed [31:0] a_pos_x = '0, a_pos_y = '0, b_pos_x = '0, b_pos_y = '0;
	logic signed [31:0] a_vel_x = '0, a_vel_y = '0, b_vel_x = '0, b_vel_y = '0;
	logic [31:0] a_mass = '0, b_mass = '0;
	logic done, collided;
	logic signed [31:0] new_a_vel_x, new_a_vel_y, new_b_vel_x, new_b_vel_y;
	logic signed [31:0] shift_x, shift_y;

	logic [31:0] radius_model = dpec_pkg::RADIUS_RESET;
	response_t pending_responses[$];
	int errors = 0;
	int pairs_sent = 0;
	int hits_seen = 0;
	longint cycles = 0;

	disc_pair_elastic_collision_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.start(start), .busy(busy),
		.a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .b_pos_x(b_pos_x), .b_pos_y(b_pos_y),
		.a_vel_x(a_vel_x), .a_vel_y(a_vel_y), .b_vel_x(b_vel_x), .b_vel_y(b_vel_y),
		.a_mass(a_mass), .b_mass(b_mass), .done(done), .collided(collided),
		.new_a_vel_x(new_a_vel_x), .new_a_vel_y(new_a_vel_y),
		.new_b_vel_x(new_b_vel_x), .new_b_vel_y(new_b_vel_y),
		.shift_x(shift_x), .shift_y(shift_y)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_disc_pair_elastic_collision_core: done, errors");
			$finish;
		end
	end

	function automatic longint div_toward_zero(longint num, longint unsigned den);
		if (num < 0) return -longint'(longint'(-num) / den);
		return longint'(longint'(num) / den);
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic response_t resolve_collision(pair_t p, logic [31:0] radius);
		response_t r;
		longint dx, dy, nx, ny, s, vdn, wa, wb, ka, kb, overlap;
		logic [66:0] dsq;
		logic [33:0] root, trial;
		longint unsigned centre_dist, twor, msum;
		dx = longint'(p.apx) - longint'(p.bpx);
		dy = longint'(p.apy) - longint'(p.bpy);
		r.hit = 1'b0;
		r.navx = p.avx; r.navy = p.avy; r.nbvx = p.bvx; r.nbvy = p.bvy;
		r.shx = '0; r.shy = '0;
		dsq = 67'(dx * dx) + 67'(dy * dy);
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (34'd1 << b);
			if (68'(trial) * 68'(trial) <= 68'(dsq)) root = trial;
		end
		centre_dist = 64'(root);
		twor = 2 * longint'(radius);
		if (centre_dist != 0 && centre_dist < twor) begin
			nx = div_toward_zero(dx * 65536, centre_dist);
			ny = div_toward_zero(dy * 65536, centre_dist);
			s = (longint'(p.avx) - p.bvx) * nx + (longint'(p.avy) - p.bvy) * ny;
			if (s <= 0) begin
				r.hit = 1'b1;
				msum = longint'(p.ma) + longint'(p.mb);
				overlap = twor - centre_dist;
				if (msum != 0) begin
					vdn = div_toward_zero(s, 65536);
					wa = (longint'(p.ma) << 24) / msum;
					wb = (longint'(p.mb) << 24) / msum;
					ka = div_toward_zero(2 * vdn * wb, 64'd1 << 24);
					kb = div_toward_zero(2 * vdn * wa, 64'd1 << 24);
					r.navx = 32'(clamp32(p.avx - div_toward_zero(ka * nx, 65536)));
					r.navy = 32'(clamp32(p.avy - div_toward_zero(ka * ny, 65536)));
					r.nbvx = 32'(clamp32(p.bvx + div_toward_zero(kb * nx, 65536)));
					r.nbvy = 32'(clamp32(p.bvy + div_toward_zero(kb * ny, 65536)));
				end
				r.shx = 32'(clamp32(div_toward_zero(nx * overlap, 64'd1 << 17)));
				r.shy = 32'(clamp32(div_toward_zero(ny * overlap, 64'd1 << 17)));
			end
		end
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		response_t want;
		if (arst_n && done) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: result with nothing expected", $realtime);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				if (collided) hits_seen++;
				if (collided !== want.hit) begin
					$display("%0t collided exp %0d got %0d", $realtime, want.hit, collided);
					errors++;
				end
				if (new_a_vel_x !== want.navx) begin
					$display("%0t new_a_vel_x exp %0d got %0d", $realtime, want.navx, new_a_vel_x);
					errors++;
				end
				if (new_a_vel_y !== want.navy) begin
					$display("%0t new_a_vel_y exp %0d got %0d", $realtime, want.navy, new_a_vel_y);
					errors++;
				end
				if (new_b_vel_x !== want.nbvx) begin
					$display("%0t new_b_vel_x exp %0d got %0d", $realtime, want.nbvx, new_b_vel_x);
					errors++;
				end
				if (new_b_vel_y !== want.nbvy) begin
					$display("%0t new_b_vel_y exp %0d got %0d", $realtime, want.nbvy, new_b_vel_y);
					errors++;
				end
				if (shift_x !== want.shx) begin
					$display("%0t shift_x exp %0d got %0d", $realtime, want.shx, shift_x);
					errors++;
				end
				if (shift_y !== want.shy) begin
					$display("%0t shift_y exp %0d got %0d", $realtime, want.shy, shift_y);
					errors++;
				end
			end
		end
	end

	// start stays high after the accepting edge; drain, or the next send before a gap, drops it
	task automatic send_pair(pair_t p, bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		a_pos_x <= p.apx; a_pos_y <= p.apy; b_pos_x <= p.bpx; b_pos_y <= p.bpy;
		a_vel_x <= p.avx; a_vel_y <= p.avy; b_vel_x <= p.bvx; b_vel_y <= p.bvy;
		a_mass <= p.ma; b_mass <= p.mb;
		do @(posedge clk); while (busy);
		pending_responses.push_back(resolve_collision(p, radius_model));
		pairs_sent++;
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_radius(logic [31:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		radius_model = value;
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'hffffffff;
			3: return 32'(int'($urandom_range(0, 400)) - 200) << 16;
			default: return $urandom;
		endcase
	endfunction

	// pair near contact range: B placed near A, velocities random
	function automatic pair_t near_pair(logic [31:0] radius);
		pair_t p;
		int span;
		span = (radius > 32'h0800_0000) ? 32'h0800_0000 : int'(radius);
		if (span < 2) span = 2;
		p.apx = $urandom; p.apy = $urandom;
		if ($urandom_range(0, 3) == 0) begin
			p.apx = rand_word(); p.apy = rand_word();
		end
		p.bpx = p.apx - int'($urandom_range(0, span)) + span / 2;
		p.bpy = p.apy - int'($urandom_range(0, span)) + span / 2;
		p.avx = ($urandom_range(0, 4) == 0) ? rand_word() : $signed($urandom) >>> $urandom_range(0, 14);
		p.avy = ($urandom_range(0, 4) == 0) ? rand_word() : $signed($urandom) >>> $urandom_range(0, 14);
		p.bvx = ($urandom_range(0, 4) == 0) ? rand_word() : $signed($urandom) >>> $urandom_range(0, 14);
		p.bvy = ($urandom_range(0, 4) == 0) ? rand_word() : $signed($urandom) >>> $urandom_range(0, 14);
		p.ma = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
		p.mb = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
		return p;
	endfunction

	function automatic pair_t any_pair();
		pair_t p;
		p.apx = rand_word(); p.apy = rand_word(); p.bpx = rand_word(); p.bpy = rand_word();
		p.avx = rand_word(); p.avy = rand_word(); p.bvx = rand_word(); p.bvy = rand_word();
		p.ma = rand_word(); p.mb = rand_word();
		return p;
	endfunction

	task automatic test_directed;
		pair_t p;
		// head-on, equal masses
		p = '{0, 0, 32'sd40 << 16, 0, 32'sd5 << 16, 0, -32'sd5 << 16, 0, 32'h10000, 32'h10000};
		send_pair(p);
		// same pair separating
		p.avx = -p.avx; p.bvx = -p.bvx;
		send_pair(p);
		// coincident centres
		p = '{32'sd100, 32'sd100, 32'sd100, 32'sd100, 1, 2, 3, 4, 32'h10000, 32'h10000};
		send_pair(p);
		// exactly two radii apart
		p = '{0, 0, 32'sd50 << 16, 0, 32'sd5 << 16, 0, 0, 0, 32'h10000, 32'h20000};
		send_pair(p);
		// touching, zero relative normal speed
		p = '{0, 0, 32'sd30 << 16, 0, 0, 32'sd3 << 16, 0, 0, 32'h10000, 32'h10000};
		send_pair(p);
		// both masses zero
		p = '{0, 0, 32'sd20 << 16, 32'sd10 << 16, 32'sd7 << 16, 0, 0, 0, 0, 0};
		send_pair(p);
		// one mass zero, each side
		p = '{0, 0, 0, 32'sd20 << 16, 0, 32'sd9 << 16, 0, -32'sd2 << 16, 0, 32'h30000};
		send_pair(p);
		p.ma = 32'h30000; p.mb = 0;
		send_pair(p);
		// extreme velocities and masses drive saturation
		p = '{0, 0, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h1, 32'hffffffff};
		send_pair(p, 1);
		p.ma = 32'hffffffff; p.mb = 32'h1;
		send_pair(p, 1);
		// far-apart extremes of position
		p = '{32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, -1, -1, 1, 1,
			32'hffffffff, 32'hffffffff};
		send_pair(p, 1);
		drain();
	endtask

	task automatic test_radius(logic [31:0] radius, int count);
		write_radius(radius);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 4) == 0) send_pair(any_pair(), i % 40 < 10);
			else send_pair(near_pair(radius), i % 40 < 10);
			// sender holds off once until everything is back
			if (i == count / 2) drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_radius(dpec_pkg::RADIUS_RESET, 300);
		test_radius(32'd0, 80);
		test_radius(32'd1, 100);
		test_radius(32'hffffffff, 350);
		test_radius(32'h00640000, 300);
		test_radius(32'h7fffffff, 300);
		test_radius($urandom, 300);
		drain();
		$display("sent %0d disc pairs over seven radius settings, %0d collisions resolved",
			pairs_sent, hits_seen);
		if (errors == 0) $display("tb_disc_pair_elastic_collision_core: done, clean");
		else $display("tb_disc_pair_elastic_collision_core: done, errors");
		$finish;
	end

endmodule
